>>> hw/rtl/itaf_pkg.sv
// shared types, character codes and mode codes of the integer to ascii formatter
`timescale 1ns / 1ps

package itaf_pkg;

	// mode codes; bit 1 set selects hexadecimal
	localparam logic [1:0] OP_UDEC = 2'd0;
	localparam logic [1:0] OP_SDEC = 2'd1;
	localparam logic [1:0] OP_HEX  = 2'd2;

	localparam int VALUE_WIDTH = 64;
	localparam int CHAR_WIDTH  = 8;

	localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;

	// digit value to ascii, lower-case hex
	localparam logic [CHAR_WIDTH-1:0] DIGIT_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};

	// input item
	typedef struct packed {
		logic [1:0]             operation;
		logic [VALUE_WIDTH-1:0] value;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [CHAR_WIDTH-1:0] character;
		logic                  last;
	} out_item_t;

	// classification handed from front to back
	typedef struct packed {
		logic is_hex;
		logic neg;
	} cmd_ctl_t;

	function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [3:0] d);
		return DIGIT_CHARS[d];
	endfunction

endpackage

>>> hw/rtl/itaf_queue.sv
// two-entry queue of classified commands between front and back
`timescale 1ns / 1ps

module itaf_queue #(
	parameter int WIDTH = 66
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             avail,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign avail    = (count_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> hw/rtl/itaf_front.sv
// front end: accepts items, picks the mode and forms the magnitude
`timescale 1ns / 1ps

module itaf_front #(
	parameter int VALUE_BITS = 64
) (
	input  logic                    number_valid,
	output logic                    number_stall,
	input  itaf_pkg::in_item_t      number,
	output logic                    push,
	output itaf_pkg::cmd_ctl_t      push_ctl,
	output logic [VALUE_BITS-1:0]   push_mag,
	input  logic                    full
);

	logic [VALUE_BITS-1:0] v;

	// bits above the width are ignored
	assign v = number.value[VALUE_BITS-1:0];

	// accept whenever the queue has room
	assign number_stall = full;
	assign push         = number_valid && !full;

	// classify: hex on bit 1 of the mode, negative only in signed decimal
	always_comb begin
		push_ctl.is_hex = number.operation[1];
		push_ctl.neg    = (number.operation == itaf_pkg::OP_SDEC) && v[VALUE_BITS-1];
		push_mag        = push_ctl.neg ? (~v + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;
	end

endmodule

>>> hw/rtl/itaf_back.sv
// back end: binary to bcd conversion and serial character output
`timescale 1ns / 1ps

module itaf_back #(
	parameter int VALUE_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    avail,
	input  itaf_pkg::cmd_ctl_t      cmd_ctl,
	input  logic [VALUE_BITS-1:0]   cmd_mag,
	output logic                    pop,
	output logic                    text_valid,
	input  logic                    text_stall,
	output itaf_pkg::out_item_t     text
);

	// decimal digits of the largest value; at least as many as hex digits
	localparam int NumDigits = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int DigW      = 4 * NumDigits;
	localparam int DcW       = $clog2(NumDigits);
	localparam int BcW       = $clog2(VALUE_BITS);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CONV  = 4'b0010,
		ST_SIGN  = 4'b0100,
		ST_DIGIT = 4'b1000
	} state_t;

	state_t                state_q;
	logic [DigW-1:0]       digits_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [BcW-1:0]        bit_cnt_q;
	logic [DcW-1:0]        dig_cnt_q;
	logic                  neg_q;
	logic                  started_q;
	logic                  out_valid_q;
	itaf_pkg::out_item_t   out_q;

	logic [DigW-1:0]       adj;
	logic [3:0]            top;
	logic                  out_free;
	logic                  skip;
	logic                  emit;
	itaf_pkg::out_item_t   out_d;

	assign text_valid = out_valid_q;
	assign text       = out_q;
	assign out_free   = !out_valid_q || !text_stall;
	assign pop        = (state_q == ST_IDLE) && avail;
	assign top        = digits_q[DigW-1 -: 4];

	// add-3 correction on every bcd digit before the shift
	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			adj[4*i +: 4] = (digits_q[4*i +: 4] >= 4'd5) ?
				(digits_q[4*i +: 4] + 4'd3) : digits_q[4*i +: 4];
		end
	end

	// leading zeros are dropped, but the final digit always goes out
	assign skip = !started_q && (top == 4'd0) && (dig_cnt_q != '0);
	assign emit = out_free && ((state_q == ST_SIGN) || ((state_q == ST_DIGIT) && !skip));

	// character for this cycle
	always_comb begin
		if (state_q == ST_SIGN) begin
			out_d.character = itaf_pkg::CH_MINUS;
			out_d.last      = 1'b0;
		end else begin
			out_d.character = itaf_pkg::digit_char(top);
			out_d.last      = (dig_cnt_q == '0);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (avail) begin
						state_q <= cmd_ctl.is_hex ? ST_DIGIT : ST_CONV;
					end
				end
				ST_CONV: begin
					if (bit_cnt_q == '0) begin
						state_q <= neg_q ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (emit && (dig_cnt_q == '0)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				neg_q     <= cmd_ctl.neg;
				started_q <= 1'b0;
				dig_cnt_q <= DcW'(NumDigits - 1);
				bit_cnt_q <= BcW'(VALUE_BITS - 1);
				mag_q     <= cmd_mag;
				digits_q  <= cmd_ctl.is_hex ? DigW'(cmd_mag) : '0;
			end
			ST_CONV: begin
				digits_q  <= {adj[DigW-2:0], mag_q[VALUE_BITS-1]};
				mag_q     <= {mag_q[VALUE_BITS-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - BcW'(1);
			end
			ST_DIGIT: begin
				if (skip || emit) begin
					digits_q  <= {digits_q[DigW-5:0], 4'd0};
					dig_cnt_q <= dig_cnt_q - DcW'(1);
				end
				if (emit) begin
					started_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!text_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= out_d;
		end
	end

	// a minus sign is never the final character
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.character == itaf_pkg::CH_MINUS)) |-> !out_q.last)
		else $error("minus sign flagged as last");

	// the final digit ends the item
	a_last_digit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIGIT) && (dig_cnt_q == '0) && out_free) |=> (state_q == ST_IDLE))
		else $error("final digit did not end the item");

	// conversion runs its full bit count and then moves to output
	a_conv_exit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CONV) && (bit_cnt_q == '0)) |=>
		((state_q == ST_SIGN) || (state_q == ST_DIGIT)))
		else $error("conversion did not hand over to output");

	// hex commands never carry a sign
	a_hex_unsigned: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !(cmd_ctl.is_hex && cmd_ctl.neg))
		else $error("signed hex command");

endmodule

>>> hw/rtl/integer_to_ascii_formatter_unit.sv
// top level of the integer to ascii formatter
`timescale 1ns / 1ps

// Integer to ascii formatter.
// number channel: one item holds a mode (unsigned decimal, signed decimal,
// lower-case hex) and a 64-bit value, of which the low VALUE_BITS are used.
// text channel: one item per character, most significant first, with last
// set on the final character. Leading zeros are dropped; zero prints "0";
// negative signed values print '-' and then the magnitude.
// The front end classifies and negates in the accept cycle and writes a
// two-entry command queue, so up to two numbers are taken ahead of the back.
// The back end pops one command, then for decimal runs a shift-add-3 bcd
// conversion over the VALUE_BITS magnitude bits (hex skips it), emits a
// '-' for a negative value, then walks the bcd register one digit per
// cycle while the output is not stalled (skipped leading zeros included).
// The first character follows the conversion and the skipped leading zeros.
// text_stall holds the output register and pauses the sign and the digit
// walk at the next character to send; the queue fills and then
// number_stall rises. Reset empties queue and output.
module integer_to_ascii_formatter_unit #(
	parameter int VALUE_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                number_valid,
	output logic                number_stall,
	input  itaf_pkg::in_item_t  number,
	output logic                text_valid,
	input  logic                text_stall,
	output itaf_pkg::out_item_t text
);

	localparam int CmdW = $bits(itaf_pkg::cmd_ctl_t) + VALUE_BITS;

	logic                  push;
	itaf_pkg::cmd_ctl_t    push_ctl;
	logic [VALUE_BITS-1:0] push_mag;
	logic                  full;
	logic                  pop;
	logic                  avail;
	logic [CmdW-1:0]       pop_data;
	itaf_pkg::cmd_ctl_t    cmd_ctl;
	logic [VALUE_BITS-1:0] cmd_mag;

	// classify and negate
	itaf_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.number_valid(number_valid),
		.number_stall(number_stall),
		.number      (number),
		.push        (push),
		.push_ctl    (push_ctl),
		.push_mag    (push_mag),
		.full        (full)
	);

	// command queue
	itaf_queue #(
		.WIDTH(CmdW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_ctl, push_mag}),
		.full     (full),
		.pop      (pop),
		.avail    (avail),
		.pop_data (pop_data)
	);

	assign cmd_ctl = itaf_pkg::cmd_ctl_t'(pop_data[CmdW-1:VALUE_BITS]);
	assign cmd_mag = pop_data[VALUE_BITS-1:0];

	// conversion and character output
	itaf_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (avail),
		.cmd_ctl   (cmd_ctl),
		.cmd_mag   (cmd_mag),
		.pop       (pop),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text      (text)
	);

endmodule
